@@ rtl/lss_pkg.sv @@
package lss_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned NUM_STAGES     = 7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SKY_LEVEL,
    CFG_ZERO_POINT,
    CFG_FAINT_LIMIT,
    CFG_INV_SPAN
  } cfg_idx_e;

  localparam logic [15:0] SKY_LEVEL_RST   = 16'd0;
  localparam logic [15:0] ZERO_POINT_RST  = 16'd0;
  localparam logic [15:0] FAINT_LIMIT_RST = 16'd6400;
  localparam logic [15:0] INV_SPAN_RST    = 16'd4096;

  // 2.5 * log10(2) in q16
  localparam logic [15:0] MAG_K      = 16'd49321;
  localparam int unsigned MAG_SHIFT  = 24;
  localparam int unsigned ROUND_BIT  = 23;
  localparam logic [15:0] DISP_MAX   = 16'hFFFF;

  // fraction bits of log2(m), m in [1,2) as q30, by repeated squaring
  function automatic logic [15:0] frac_log2(input logic [63:0] m_in);
    logic [63:0] m;
    logic [15:0] r;
    m = m_in;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/log_surface_brightness_stretch.sv @@
// logarithmic surface brightness stretch
//
// input channel: in_valid_i / in_stall_o with pixel_value_i, one word per clock
// output channel: out_valid_o / out_stall_i with display_value_o
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i
//   0 sky level, 1 zero point (q7.8), 2 faint limit (q7.8), 3 inv span (q8.8);
//   ready always high; user writes only while the pipeline is empty, unchecked
//
// seven register stages: subtract sky, leading one and table index, log
// fraction lookup, magnitude multiply, zero point and faint limit, span
// multiply, clamp. throughput is one word per clock while the output
// is not stalled.
//
// each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and the input
// is only stalled once every stage is full. reset empties the pipeline and
// loads the register defaults.
module log_surface_brightness_stretch #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [PIXEL_BITS-1:0]              pixel_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        display_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lss_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [lss_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned NS = lss_pkg::NUM_STAGES;
  localparam int unsigned DW = $clog2(PIXEL_BITS + 1) + 16;

  logic [15:0] sky_level_q, zero_point_q, faint_limit_q, inv_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sky_level_q   <= lss_pkg::SKY_LEVEL_RST;
      zero_point_q  <= lss_pkg::ZERO_POINT_RST;
      faint_limit_q <= lss_pkg::FAINT_LIMIT_RST;
      inv_span_q    <= lss_pkg::INV_SPAN_RST;
    end else if (cfg_valid_i) begin
      unique case (lss_pkg::cfg_idx_e'(cfg_index_i))
        lss_pkg::CFG_SKY_LEVEL:   sky_level_q   <= cfg_data_i;
        lss_pkg::CFG_ZERO_POINT:  zero_point_q  <= cfg_data_i;
        lss_pkg::CFG_FAINT_LIMIT: faint_limit_q <= cfg_data_i;
        lss_pkg::CFG_INV_SPAN:    inv_span_q    <= cfg_data_i;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // per stage valid and advance
  logic [NS:1] valid_d, valid_q;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !valid_q[NS] || !out_stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[1] = en[1] ? in_valid_i : valid_q[1];
    for (int k = 2; k <= NS; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = valid_q[NS];

  logic [PIXEL_BITS-1:0] signal;
  logic                  pos1, pos3;
  logic [DW-1:0]         depth;

  lss_sub #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_sub (
    .clk_i         (clk_i),
    .en_i          (en[1]),
    .pixel_value_i (pixel_value_i),
    .sky_level_i   (sky_level_q),
    .signal_o      (signal),
    .pos_o         (pos1)
  );

  lss_log #(
    .PIXEL_BITS     (PIXEL_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log (
    .clk_i    (clk_i),
    .en_i     (en[3:2]),
    .signal_i (signal),
    .pos_i    (pos1),
    .depth_o  (depth),
    .pos_o    (pos3)
  );

  lss_mag #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_mag (
    .clk_i           (clk_i),
    .en_i            (en[7:4]),
    .depth_i         (depth),
    .pos_i           (pos3),
    .zero_point_i    (zero_point_q),
    .faint_limit_i   (faint_limit_q),
    .inv_span_i      (inv_span_q),
    .display_value_o (display_value_o)
  );

endmodule

@@ rtl/lss_sub.sv @@
module lss_sub #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic [15:0]           sky_level_i,
  output logic [PIXEL_BITS-1:0] signal_o,
  output logic                  pos_o
);

  logic [PIXEL_BITS-1:0] sky;
  logic [PIXEL_BITS-1:0] signal_d, signal_q;
  logic                  pos_d, pos_q;

  assign sky      = PIXEL_BITS'(sky_level_i);
  assign signal_d = pixel_value_i - sky;
  assign pos_d    = pixel_value_i > sky;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      signal_q <= signal_d;
      pos_q    <= pos_d;
    end
  end

  assign signal_o = signal_q;
  assign pos_o    = pos_q;

endmodule

@@ rtl/lss_log.sv @@
module lss_log #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  logic                                   clk_i,
  input  logic [1:0]                             en_i,
  input  logic [PIXEL_BITS-1:0]                  signal_i,
  input  logic                                   pos_i,
  output logic [$clog2(PIXEL_BITS+1)+16-1:0]     depth_o,
  output logic                                   pos_o
);

  localparam int unsigned EW       = $clog2(PIXEL_BITS);
  localparam int unsigned DW       = $clog2(PIXEL_BITS + 1) + 16;
  localparam int unsigned TAB_SIZE = 1 << LOG_TABLE_BITS;
  localparam int unsigned NW       = PIXEL_BITS + LOG_TABLE_BITS;

  logic [15:0] log_tab [TAB_SIZE];

  for (genvar i = 0; i < TAB_SIZE; i++) begin : g_tab
    localparam logic [63:0] MANT = 64'(TAB_SIZE + i) << (30 - LOG_TABLE_BITS);
    localparam logic [15:0] FRAC = lss_pkg::frac_log2(MANT);
    assign log_tab[i] = FRAC;
  end

  logic [EW-1:0]             exp_d, exp_q;
  logic [NW-1:0]             norm;
  logic [LOG_TABLE_BITS-1:0] idx_d, idx_q;
  logic                      pos2_q;
  logic [DW-1:0]             l2, depth_d, depth_q;
  logic                      pos3_q;

  // leading one position
  always_comb begin
    exp_d = '0;
    for (int i = 0; i < PIXEL_BITS; i++) begin
      if (signal_i[i]) begin
        exp_d = EW'(i);
      end
    end
  end

  assign norm  = {signal_i, {LOG_TABLE_BITS{1'b0}}} << (EW'(PIXEL_BITS - 1) - exp_d);
  assign idx_d = norm[NW-2 -: LOG_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      exp_q  <= exp_d;
      idx_q  <= idx_d;
      pos2_q <= pos_i;
    end
  end

  assign l2      = (DW'(exp_q) << 16) | DW'(log_tab[idx_q]);
  assign depth_d = (DW'(PIXEL_BITS) << 16) - l2;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      depth_q <= depth_d;
      pos3_q  <= pos2_q;
    end
  end

  assign depth_o = depth_q;
  assign pos_o   = pos3_q;

endmodule

@@ rtl/lss_mag.sv @@
module lss_mag #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                               clk_i,
  input  logic [3:0]                         en_i,
  input  logic [$clog2(PIXEL_BITS+1)+16-1:0] depth_i,
  input  logic                               pos_i,
  input  logic [15:0]                        zero_point_i,
  input  logic [15:0]                        faint_limit_i,
  input  logic [15:0]                        inv_span_i,
  output logic [15:0]                        display_value_o
);

  localparam int unsigned DW   = $clog2(PIXEL_BITS + 1) + 16;
  localparam int unsigned PW   = DW + 16;
  localparam int unsigned QW   = PW + 1 - lss_pkg::MAG_SHIFT;
  localparam int unsigned MUW  = ((QW + 1 > 16) ? QW + 1 : 16) + 1;
  localparam int unsigned DFW  = MUW + 1;
  localparam int unsigned VW   = DFW + 17;

  logic [PW-1:0]         prod_d, prod_q;
  logic                  pos4_q;
  logic [PW:0]           rnd;
  logic [QW-1:0]         mag_q8;
  logic [MUW-1:0]        mu;
  logic signed [DFW-1:0] diff_d, diff_q;
  logic                  pos5_q;
  logic signed [VW-1:0]  v_d, v_q;
  logic                  pos6_q;
  logic [15:0]           disp_d, disp_q;

  assign prod_d = PW'(depth_i) * PW'(lss_pkg::MAG_K);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      pos4_q <= pos_i;
    end
  end

  // round half up to q8, then add zero point and take from faint limit
  assign rnd    = {1'b0, prod_q} + ((PW + 1)'(1) << lss_pkg::ROUND_BIT);
  assign mag_q8 = rnd[PW:lss_pkg::MAG_SHIFT];
  assign mu     = {{(MUW - 16){zero_point_i[15]}}, zero_point_i}
                + {{(MUW - QW){1'b0}}, mag_q8};
  assign diff_d = $signed({{(DFW - 16){faint_limit_i[15]}}, faint_limit_i})
                - $signed({mu[MUW-1], mu});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      diff_q <= diff_d;
      pos5_q <= pos4_q;
    end
  end

  assign v_d = diff_q * $signed({1'b0, inv_span_i});

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      v_q    <= v_d;
      pos6_q <= pos5_q;
    end
  end

  always_comb begin
    priority if (!pos6_q || v_q <= 0) begin
      disp_d = '0;
    end else if (v_q >= 65535) begin
      disp_d = lss_pkg::DISP_MAX;
    end else begin
      disp_d = v_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      disp_q <= disp_d;
    end
  end

  assign display_value_o = disp_q;

endmodule

@@ rtl/lss_chk.sv @@
module lss_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] display_value_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(display_value_o))
    else $error("stalled result word changed");

  // an empty output stage never back-pressures the input
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output empty");

  // no stall at the output means no stall at the input
  a_flow_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output flows");

  // an accepted word reaches out_valid_o through every stage when the output does not stall
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result word missing after pipeline latency");

endmodule

bind log_surface_brightness_stretch lss_chk u_lss_chk (.*);
